// ===== src/btc_pkg.sv =====
package btc_pkg;

    // Largest matrix the block holds; also the row width and the most rows
    // emitted for one computation.
    localparam int MAX_VERTICES = 16;
    localparam int ROW_W        = 16;
    localparam int IDX_W        = 4;
    localparam int SIZE_W       = 5;

    // Configuration register map (register index, byte address / 4).
    localparam logic REG_SIZE_IN_USE = 1'b0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
        logic             last_row;
    } row_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_row_index;
        logic [ROW_W-1:0] closure_row;
        logic             last_out;
    } result_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             copy;
        logic             pivot;
        logic             emit;
        logic [IDX_W-1:0] pivot_idx;
        logic [IDX_W-1:0] out_index;
        logic             out_last;
    } btc_cmd_t;

    // Number of vertices in use, clamped to 1..MAX_VERTICES.
    function automatic logic [SIZE_W-1:0] active_size(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] n;
        begin
            n = size;
            if (n == '0)
                n = SIZE_W'(1);
            if (n > SIZE_W'(MAX_VERTICES))
                n = SIZE_W'(MAX_VERTICES);
            return n;
        end
    endfunction

    // Bit j is set where j lies below n.
    function automatic logic [ROW_W-1:0] lane_mask(input logic [SIZE_W-1:0] n);
        logic [ROW_W-1:0] m;
        begin
            for (int j = 0; j < ROW_W; j++)
            begin
                m[j] = (SIZE_W'(j) < n);
            end
            return m;
        end
    endfunction

endpackage

// ===== src/btc_datapath.sv =====
module btc_datapath (
    input  logic                  clk,
    input  logic                  row_we,
    input  btc_pkg::row_item_t    row_item,
    input  logic [btc_pkg::SIZE_W-1:0] n_active,
    input  btc_pkg::btc_cmd_t     cmd,
    output btc_pkg::result_item_t result_item
);

    logic [btc_pkg::ROW_W-1:0] store_reg [btc_pkg::MAX_VERTICES];
    logic [btc_pkg::ROW_W-1:0] work_reg  [btc_pkg::MAX_VERTICES];
    logic [btc_pkg::ROW_W-1:0] work_next [btc_pkg::MAX_VERTICES];
    btc_pkg::result_item_t     out_reg;
    btc_pkg::result_item_t     out_next;
    logic [btc_pkg::ROW_W-1:0] mask;
    logic [btc_pkg::ROW_W-1:0] pivot_row;

    assign mask      = btc_pkg::lane_mask(n_active);
    assign pivot_row = work_reg[cmd.pivot_idx];

    // Row store, written once per accepted row transaction.
    always_ff @(posedge clk)
    begin
        if (row_we)
            store_reg[row_item.row_index] <= row_item.row_bits;
    end

    // Working copy: loaded masked, updated for one pivot a cycle across all
    // rows, then shifted towards row 0 as results are taken.
    always_comb
    begin
        for (int i = 0; i < btc_pkg::MAX_VERTICES; i++)
        begin
            work_next[i] = work_reg[i];
            if (cmd.copy)
                work_next[i] = mask[i] ? (store_reg[i] & mask) : '0;
            else if (cmd.pivot)
            begin
                if (work_reg[i][cmd.pivot_idx])
                    work_next[i] = work_reg[i] | pivot_row;
            end
            else if (cmd.emit)
            begin
                if (i == btc_pkg::MAX_VERTICES - 1)
                    work_next[i] = '0;
                else
                    work_next[i] = work_reg[(i + 1) % btc_pkg::MAX_VERTICES];
            end
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.emit)
        begin
            out_next.out_row_index = cmd.out_index;
            out_next.closure_row   = work_reg[0];
            out_next.last_out      = cmd.out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < btc_pkg::MAX_VERTICES; i++)
        begin
            work_reg[i] <= work_next[i];
        end
        out_reg <= out_next;
    end

    assign result_item = out_reg;

endmodule

// ===== src/btc_controller.sv =====
module btc_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        row_accept,
    input  logic                        last_row,
    input  logic [btc_pkg::SIZE_W-1:0]  n_active,
    input  logic                        result_ready,
    output logic                        row_ready,
    output logic                        result_valid,
    output btc_pkg::btc_cmd_t           cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_COPY  = 4'b0010,
        ST_PIVOT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [btc_pkg::SIZE_W-1:0]  cnt_reg, cnt_next;
    logic                        valid_reg, valid_next;
    logic [btc_pkg::SIZE_W-1:0]  n_m1;
    logic                        at_end;
    logic                        out_free;

    assign n_m1     = n_active - btc_pkg::SIZE_W'(1);
    assign at_end   = (cnt_reg == n_m1);
    assign out_free = !valid_reg || result_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        valid_next    = valid_reg && !result_ready;
        cmd           = '0;
        cmd.pivot_idx = cnt_reg[btc_pkg::IDX_W-1:0];
        cmd.out_index = cnt_reg[btc_pkg::IDX_W-1:0];
        cmd.out_last  = at_end;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (row_accept && last_row)
                    state_next = ST_COPY;
            end
            ST_COPY:
            begin
                cmd.copy   = 1'b1;
                cnt_next   = '0;
                state_next = ST_PIVOT;
            end
            ST_PIVOT:
            begin
                cmd.pivot = 1'b1;
                if (at_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                    cnt_next = cnt_reg + btc_pkg::SIZE_W'(1);
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    if (at_end)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        cnt_next = cnt_reg + btc_pkg::SIZE_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign row_ready    = (state_reg == ST_IDLE);
    assign result_valid = valid_reg;

endmodule

// ===== src/boolean_transitive_closure_unit.sv =====
// A matrix of n rows takes n row loads, one copy step, n pivot steps (one per cycle
// over all rows) and n result transactions. Closure rows leave from a register, one
// closure row a cycle while the consumer keeps up. Rows are only taken while idle,
// so the next matrix waits until the last closure row of this one has been emitted.
// Reset (rst_n, asynchronous, active low) idles the control and sets size_in_use to 16.
module boolean_transitive_closure_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    // Row input channel.
    input  logic                  row_valid,
    output logic                  row_ready,
    input  btc_pkg::row_item_t    row_item,
    // Closure result channel.
    output logic                  result_valid,
    input  logic                  result_ready,
    output btc_pkg::result_item_t result_item,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // The only register is size_in_use at byte address 0. Bit 2 of the
    // address selects the register slot; the lowest bits are ignored.
    logic [btc_pkg::SIZE_W-1:0] size_reg;
    logic [btc_pkg::SIZE_W-1:0] size_next;
    logic [btc_pkg::SIZE_W-1:0] n_active;
    logic                       cfg_write;
    logic                       row_accept;
    btc_pkg::btc_cmd_t          cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        size_next = size_reg;
        if (cfg_write && (paddr[2] == btc_pkg::REG_SIZE_IN_USE))
            size_next = pwdata[btc_pkg::SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= btc_pkg::SIZE_RESET;
        else
            size_reg <= size_next;
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == btc_pkg::REG_SIZE_IN_USE)
            prdata = {{(32 - btc_pkg::SIZE_W){1'b0}}, size_reg};
    end

    // A size of zero is treated as one vertex and anything above the store
    // depth as the full store.
    assign n_active = btc_pkg::active_size(size_reg);

    // Rows are only taken while the controller is idle. Each accepted
    // transaction writes its row into the store; the one flagged as last then
    // starts the closure from the rows as stored, so the stored matrix is
    // never changed by the computation itself.
    assign row_accept = row_valid && row_ready;

    btc_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_accept   (row_accept),
        .last_row     (row_item.last_row),
        .n_active     (n_active),
        .result_ready (result_ready),
        .row_ready    (row_ready),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // The datapath keeps a working copy of the matrix with unused rows and
    // columns cleared. Each pivot cycle ORs the pivot row into every row that
    // reaches the pivot, which is Warshall's update applied to all rows at
    // once. Results are then taken from row 0 while the copy shifts up.
    btc_datapath u_dp (
        .clk         (clk),
        .row_we      (row_accept),
        .row_item    (row_item),
        .n_active    (n_active),
        .cmd         (cmd),
        .result_item (result_item)
    );

endmodule

// ===== src/btc_checker.sv =====
module btc_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  row_valid,
    input  logic                  row_ready,
    input  btc_pkg::row_item_t    row_item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  btc_pkg::result_item_t result_item
);

    // A result that is held back keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

    // The last-row transaction makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_ready && row_item.last_row |=> !row_ready)
    else $error("rows accepted during computation");

    // Taking a result that is not the final one brings the next one at once,
    // and the block only goes idle once that one is the final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result_item.last_out
        |=> result_valid && (!row_ready || result_item.last_out))
    else $error("block went idle before the final result");

    // While rows are accepted, only the final result of a matrix can wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_ready && result_valid |-> result_item.last_out)
    else $error("non-final result pending while idle");

endmodule

bind boolean_transitive_closure_unit btc_checker u_btc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .row_valid    (row_valid),
    .row_ready    (row_ready),
    .row_item     (row_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

// ===== tb/sv/boolean_transitive_closure_unit_tb.sv =====
module boolean_transitive_closure_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Byte address of the size register, and the timing figures of the run.
    localparam logic [2:0] SIZE_ADDR    = 3'(4 * btc_pkg::REG_SIZE_IN_USE);
    localparam int         DRAIN_CYCLES = 3 * btc_pkg::MAX_VERTICES + 12;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         RANDOM_ITEMS = 460;
    localparam int         IDLE_PCT     = 23;

    // One line of the directed table: either a write of size_in_use or a row
    // transaction. Where typed_hit is set, every closure row that the
    // transaction causes is expected to equal typed_row.
    typedef struct {
        bit                         is_cfg;
        logic [31:0]                size_word;
        btc_pkg::row_item_t         item;
        bit                         typed_hit;
        logic [btc_pkg::ROW_W-1:0]  typed_row;
    } directed_step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  row_valid = 1'b0;
    logic                  row_ready;
    btc_pkg::row_item_t    row_item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    btc_pkg::result_item_t result_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Our own copy of the block's state: the stored rows and the size register.
    logic [btc_pkg::ROW_W-1:0]  row_mem [btc_pkg::MAX_VERTICES];
    logic [btc_pkg::SIZE_W-1:0] size_reg = btc_pkg::SIZE_RESET;
    // Rows that the stimulus has written so far; a computation is only ever
    // started once every row in use has been written at least once.
    bit                    row_written [btc_pkg::MAX_VERTICES];

    // Closure rows still owed by the block, oldest first.
    btc_pkg::result_item_t closure_q [$];

    int                    fail_count = 0;
    int                    stall_cycles = 0;
    int                    items_sent = 0;
    int                    idle_pct = IDLE_PCT;
    bit                    hold_request = 1'b0;
    bit                    typed_on = 1'b0;
    logic [btc_pkg::ROW_W-1:0] typed_val = '0;

    boolean_transitive_closure_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (row_valid),
        .row_ready    (row_ready),
        .row_item     (row_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    initial
    begin
        foreach (row_mem[i])
        begin
            row_mem[i] = '0;
            row_written[i] = 1'b0;
        end
    end

    // Stores one accepted row transaction and, where it carries the last-row
    // flag, works out the closure of the rows in use by Warshall's pivot
    // scheme and queues one expected result per row.
    function automatic void absorb_row(input btc_pkg::row_item_t it);
        logic [btc_pkg::ROW_W-1:0] reach [btc_pkg::MAX_VERTICES];
        logic [btc_pkg::ROW_W-1:0] lanes;
        int                        n;
        btc_pkg::result_item_t     r;
        row_mem[it.row_index] = it.row_bits;
        if (!it.last_row)
            return;
        n = int'(size_reg);
        if (n < 1)
            n = 1;
        if (n > btc_pkg::MAX_VERTICES)
            n = btc_pkg::MAX_VERTICES;
        lanes = '0;
        for (int j = 0; j < n; j++)
            lanes[j] = 1'b1;
        // Columns at or beyond n read as zero.
        for (int i = 0; i < n; i++)
            reach[i] = row_mem[i] & lanes;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (reach[i][k])
                    reach[i] = reach[i] | reach[k];
            end
        end
        for (int i = 0; i < n; i++)
        begin
            r.out_row_index = btc_pkg::IDX_W'(i);
            r.closure_row   = typed_on ? typed_val : reach[i];
            r.last_out      = (i == n - 1);
            closure_q.push_back(r);
        end
    endfunction

    // Sampling happens only at the rising edge; every input changes at the
    // falling edge, so nothing here races with the drivers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((row_valid && row_ready) || (result_valid && result_ready)
                || (psel && penable && pready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;

            if (row_valid && row_ready)
                absorb_row(row_item);

            if (result_valid && result_ready)
            begin
                if (closure_q.size() == 0)
                begin
                    $error("closure row %0d arrived with nothing expected",
                           result_item.out_row_index);
                    fail_count++;
                end
                else
                begin
                    btc_pkg::result_item_t want;
                    want = closure_q.pop_front();
                    if (result_item.out_row_index !== want.out_row_index)
                    begin
                        $error("out_row_index: expected %0d, actual %0d",
                               want.out_row_index, result_item.out_row_index);
                        fail_count++;
                    end
                    if (result_item.closure_row !== want.closure_row)
                    begin
                        $error("closure_row: expected %04h, actual %04h",
                               want.closure_row, result_item.closure_row);
                        fail_count++;
                    end
                    if (result_item.last_out !== want.last_out)
                    begin
                        $error("last_out: expected %0b, actual %0b",
                               want.last_out, result_item.last_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    // The consumer. It idles at random, and once on request it holds off for
    // a long stretch so that the block fills up and has to refuse new rows.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // A run in which no transaction of any kind completes for a long time has
    // hung.
    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("** boolean_transitive_closure_unit: FAILED **");
        $finish;
    end

    // Offers one row transaction, after a random gap, and returns at the
    // falling edge that follows its acceptance. Valid is only lowered when a
    // gap is actually taken, so a back-to-back transaction keeps it high.
    task automatic offer_row(input btc_pkg::row_item_t it);
        if ($urandom_range(99) < idle_pct)
        begin
            row_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
        row_item  <= it;
        row_valid <= 1'b1;
        row_written[it.row_index] = 1'b1;
        @(posedge clk);
        while (!row_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Waits until every owed closure row has come out, then gives the block
    // time to settle before anything is reconfigured or the run is judged.
    task automatic drain_results();
        row_valid <= 1'b0;
        while (closure_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // Reads size_in_use back and compares the bits the register holds.
    task automatic read_size(input logic [btc_pkg::SIZE_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SIZE_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[btc_pkg::SIZE_W-1:0] !== want)
        begin
            $error("size_in_use read back: expected %0d, actual %0d",
                   want, prdata[btc_pkg::SIZE_W-1:0]);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Writes size_in_use with a setup phase and an access phase, then reads it back.
    task automatic program_size(input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        size_reg = word[btc_pkg::SIZE_W-1:0];
        read_size(word[btc_pkg::SIZE_W-1:0]);
    endtask

    // Row contents of varied density: empty, full, sparse, dense or plain.
    function automatic logic [btc_pkg::ROW_W-1:0] pick_bits();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return btc_pkg::ROW_W'($urandom & $urandom & $urandom);
            3:       return btc_pkg::ROW_W'($urandom | $urandom);
            default: return btc_pkg::ROW_W'($urandom);
        endcase
    endfunction

    // One matrix for a size of n rows. Most are well-formed: every row in use
    // loaded in shuffled order with the odd stray row mixed in, the last one
    // flagged. Some are a bare last-row transaction that recomputes from the
    // rows already stored, and some are broken loads that never finish.
    task automatic load_matrix(input int n);
        int                 order [btc_pkg::MAX_VERTICES];
        int                 pick;
        int                 swap;
        int                 mode;
        bit                 all_written;
        bit                 late_flag;
        btc_pkg::row_item_t it;
        mode = $urandom_range(99);
        late_flag = ($urandom_range(99) < 15);
        all_written = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (!row_written[i])
                all_written = 1'b0;
        end
        if (mode < 10 && all_written)
        begin
            it.row_index = btc_pkg::IDX_W'($urandom);
            it.row_bits  = pick_bits();
            it.last_row  = 1'b1;
            offer_row(it);
        end
        else if (mode < 25)
        begin
            repeat ($urandom_range(n, 1))
            begin
                it.row_index = btc_pkg::IDX_W'($urandom);
                it.row_bits  = pick_bits();
                it.last_row  = 1'b0;
                offer_row(it);
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
                order[i] = i;
            for (int i = n - 1; i > 0; i--)
            begin
                pick = $urandom_range(i);
                swap = order[i];
                order[i] = order[pick];
                order[pick] = swap;
            end
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(99) < 15)
                begin
                    it.row_index = btc_pkg::IDX_W'($urandom);
                    it.row_bits  = pick_bits();
                    it.last_row  = 1'b0;
                    offer_row(it);
                end
                it.row_index = btc_pkg::IDX_W'(order[i]);
                it.row_bits  = pick_bits();
                it.last_row  = (i == n - 1) && !late_flag;
                offer_row(it);
            end
            // The flag may also come on a row of its own, often one outside
            // the matrix in use.
            if (late_flag)
            begin
                if (n < btc_pkg::MAX_VERTICES)
                    it.row_index =
                        btc_pkg::IDX_W'($urandom_range(btc_pkg::MAX_VERTICES - 1, n));
                else
                    it.row_index = btc_pkg::IDX_W'($urandom);
                it.row_bits = pick_bits();
                it.last_row = 1'b1;
                offer_row(it);
            end
        end
    endtask

    function automatic directed_step_t dstep(input bit is_cfg, input logic [31:0] word,
                                             input logic [btc_pkg::IDX_W-1:0] idx,
                                             input logic [btc_pkg::ROW_W-1:0] bits,
                                             input logic last, input bit typed_hit,
                                             input logic [btc_pkg::ROW_W-1:0] typed_row);
        directed_step_t s;
        s.is_cfg             = is_cfg;
        s.size_word          = word;
        s.item.row_index     = idx;
        s.item.row_bits      = bits;
        s.item.last_row      = last;
        s.typed_hit          = typed_hit;
        s.typed_row          = typed_row;
        return s;
    endfunction

    initial
    begin : stimulus
        directed_step_t tbl [$];
        int             size_pick;
        int             matrices;
        bit             hold_done;
        logic [31:0]    word;

        hold_done = 1'b0;

        // Directed table. With a single vertex the closure holds at most the self
        // loop, and a matrix of all ones closes to all ones, so those rows
        // carry their answer; the rest are left to the predictor.
        tbl.push_back(dstep(1, 32'd1,          0,     16'h0000, 0, 0, 16'h0000));
        tbl.push_back(dstep(0, 0,              4'd0,  16'h0001, 1, 1, 16'h0001));
        // Columns beyond a one-vertex matrix are ignored.
        tbl.push_back(dstep(0, 0,              4'd0,  16'hFFFE, 1, 1, 16'h0000));
        tbl.push_back(dstep(0, 0,              4'd0,  16'h0000, 0, 0, 16'h0000));
        // The last-row flag on a row outside the matrix still starts a pass.
        tbl.push_back(dstep(0, 0,              4'd15, 16'hFFFF, 1, 1, 16'h0000));
        // A size of zero, with junk in the upper data bits, acts as one.
        tbl.push_back(dstep(1, 32'hFFFF_FFE0,  0,     16'h0000, 0, 0, 16'h0000));
        tbl.push_back(dstep(0, 0,              4'd0,  16'hFFFF, 1, 1, 16'h0001));
        // A two-vertex cycle loaded out of order.
        tbl.push_back(dstep(1, 32'd2,          0,     16'h0000, 0, 0, 16'h0000));
        tbl.push_back(dstep(0, 0,              4'd1,  16'h0001, 0, 0, 16'h0000));
        tbl.push_back(dstep(0, 0,              4'd0,  16'h0002, 1, 0, 16'h0000));
        // Oversized setting clamps to the full matrix, here all ones.
        tbl.push_back(dstep(1, 32'd17,         0,     16'h0000, 0, 0, 16'h0000));
        for (int i = 0; i < btc_pkg::MAX_VERTICES; i++)
            tbl.push_back(dstep(0, 0, btc_pkg::IDX_W'(i), 16'hFFFF,
                                (i == btc_pkg::MAX_VERTICES - 1),
                                (i == btc_pkg::MAX_VERTICES - 1), 16'hFFFF));
        // Vertex 15 loses its out-edges, so it is a sink of every other row.
        tbl.push_back(dstep(0, 0,              4'd15, 16'h0000, 1, 0, 16'h0000));
        tbl.push_back(dstep(1, 32'd31,         0,     16'h0000, 0, 0, 16'h0000));
        tbl.push_back(dstep(0, 0,              4'd3,  16'h0008, 1, 0, 16'h0000));

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The register comes out of reset at the full size.
        read_size(btc_pkg::SIZE_RESET);

        foreach (tbl[k])
        begin
            if (tbl[k].is_cfg)
            begin
                drain_results();
                program_size(tbl[k].size_word);
            end
            else
            begin
                typed_on  = tbl[k].typed_hit;
                typed_val = tbl[k].typed_row;
                offer_row(tbl[k].item);
                typed_on  = 1'b0;
            end
        end

        // Random part: phases of one size setting each, mostly small
        // matrices, now and then the full size or an out-of-range value.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            drain_results();
            idle_pct = (items_sent >= 150 && items_sent < 250) ? 0 : IDLE_PCT;
            size_pick = $urandom_range(99);
            if (size_pick < 60)
                size_pick = $urandom_range(6, 1);
            else if (size_pick < 75)
                size_pick = $urandom_range(15, 7);
            else if (size_pick < 88)
                size_pick = btc_pkg::MAX_VERTICES;
            else if (size_pick < 92)
                size_pick = 0;
            else
                size_pick = $urandom_range(31, 17);
            matrices = $urandom_range(4, 1);
            // Once in the run the consumer stops for a long while as a few
            // matrices are pushed in, so that the input has to back up.
            if (!hold_done && items_sent >= 300)
            begin
                hold_done = 1'b1;
                size_pick = 8;
                matrices = 4;
            end
            word = ($urandom & ~32'h1F) | 32'(size_pick);
            program_size(word);
            if (size_pick == 8 && matrices == 4 && hold_done && items_sent >= 300
                && !hold_request && idle_pct == IDLE_PCT)
                hold_request = 1'b1;
            if (size_pick < 1)
                size_pick = 1;
            if (size_pick > btc_pkg::MAX_VERTICES)
                size_pick = btc_pkg::MAX_VERTICES;
            repeat (matrices)
                load_matrix(size_pick);
        end

        drain_results();
        if (fail_count == 0 && closure_q.size() == 0)
            $display("** boolean_transitive_closure_unit: PASSED **");
        else
            $display("** boolean_transitive_closure_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/btc_pkg.sv
src/btc_datapath.sv
src/btc_controller.sv
src/boolean_transitive_closure_unit.sv
src/btc_checker.sv
tb/sv/boolean_transitive_closure_unit_tb.sv
